>>> design/assert_macros.svh
// Assertion helpers. Both sample on clk and stay off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define CGCF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cgcf assertion failed");

// Next-cycle implication
`define CGCF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cgcf assertion failed");

`endif

>>> design/cgcf_pkg.sv
package cgcf_pkg;

  localparam int N_VTX     = 7;
  localparam int VTX_W     = 3;
  localparam int MASK_W    = N_VTX * (N_VTX - 1) / 2;
  localparam int PAIR_W    = 5;
  localparam int CNT_W     = VTX_W;
  localparam int CNT_DEPTH = 2 * (1 << VTX_W);
  localparam int CADDR_W   = VTX_W + 1;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT = 1'b1;

  typedef logic [N_VTX-1:0][VTX_W-1:0] perm_t;

  typedef struct packed {
    logic              start;
    logic [VTX_W-1:0]  n;
    logic [VTX_W-1:0]  a;
    logic [MASK_W-1:0] mask;
  } job_t;

  typedef struct packed {
    logic idle;
    logic visit;
  } heap_stat_t;

  // bit position of edge (u,v), u != v: hi*(hi-1)/2 + lo
  function automatic logic [PAIR_W-1:0] pair_idx(input logic [VTX_W-1:0] u,
                                                 input logic [VTX_W-1:0] v);
    logic [VTX_W-1:0]   lo;
    logic [VTX_W-1:0]   hi;
    logic [2*VTX_W-1:0] prod;
    lo   = (u < v) ? u : v;
    hi   = (u < v) ? v : u;
    prod = {{VTX_W{1'b0}}, hi} * ({{VTX_W{1'b0}}, hi} - {{(2*VTX_W-1){1'b0}}, 1'b1});
    return prod[PAIR_W:1] + {{(PAIR_W-VTX_W){1'b0}}, lo};
  endfunction

endpackage

>>> design/cgcf_ram.sv
module cgcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/cgcf_heap.sv
module cgcf_heap (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cgcf_pkg::job_t       job,
  output cgcf_pkg::perm_t      perm,
  output cgcf_pkg::heap_stat_t stat
);

  localparam logic [1:0] HS_IDLE  = 2'd0;
  localparam logic [1:0] HS_CLEAR = 2'd1;
  localparam logic [1:0] HS_ISSUE = 2'd2;
  localparam logic [1:0] HS_RUN   = 2'd3;

  localparam logic PART_X = 1'b0;
  localparam logic PART_H = 1'b1;

  logic [1:0]                     hs_r, hs_nxt;
  logic                           part_r, part_nxt;
  logic [cgcf_pkg::VTX_W-1:0]     lvl_r, lvl_nxt;
  logic [cgcf_pkg::CADDR_W-1:0]   clr_r, clr_nxt;
  logic                           fwd_r, fwd_nxt;
  logic [cgcf_pkg::CNT_W-1:0]     fwd_data_r, fwd_data_nxt;
  logic [cgcf_pkg::VTX_W-1:0]     n_r, n_nxt;
  logic [cgcf_pkg::VTX_W-1:0]     a_r, a_nxt;
  cgcf_pkg::perm_t                perm_r, perm_nxt;
  logic                           visit_r;

  logic                           we, re;
  logic [cgcf_pkg::CADDR_W-1:0]   waddr, raddr;
  logic [cgcf_pkg::CNT_W-1:0]     wdata, rdata;

  logic [cgcf_pkg::VTX_W-1:0]     kx, k_cur, base, tgt_k, tgt_lvl;
  logic [cgcf_pkg::VTX_W-1:0]     pos_a, pos_b;
  logic [cgcf_pkg::CNT_W-1:0]     cur_c;
  logic                           tgt_part, do_swap, start_ok;

  // Heap counters c[level], one bank per part
  cgcf_ram #(
    .WIDTH (cgcf_pkg::CNT_W),
    .DEPTH (cgcf_pkg::CNT_DEPTH)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    kx       = n_r - a_r;
    k_cur    = (part_r == PART_H) ? a_r : kx;
    base     = (part_r == PART_H) ? '0 : a_r;
    cur_c    = fwd_r ? fwd_data_r : rdata;
    start_ok = (hs_r == HS_IDLE) && job.start;

    hs_nxt       = hs_r;
    part_nxt     = part_r;
    lvl_nxt      = lvl_r;
    clr_nxt      = clr_r;
    fwd_nxt      = 1'b0;
    fwd_data_nxt = fwd_data_r;
    n_nxt        = n_r;
    a_nxt        = a_r;
    we           = 1'b0;
    waddr        = {part_r, lvl_r};
    wdata        = '0;
    re           = 1'b0;
    raddr        = {part_r, lvl_r};
    do_swap      = 1'b0;
    pos_a        = base;
    pos_b        = base + lvl_r;
    tgt_part     = part_r;
    tgt_lvl      = lvl_r;
    tgt_k        = k_cur;

    case (hs_r)
      HS_IDLE: begin
        if (job.start) begin
          hs_nxt  = HS_CLEAR;
          clr_nxt = '0;
          n_nxt   = job.n;
          a_nxt   = job.a;
        end
      end
      HS_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == cgcf_pkg::CADDR_W'(cgcf_pkg::CNT_DEPTH - 1)) begin
          hs_nxt   = HS_ISSUE;
          part_nxt = PART_X;
          lvl_nxt  = cgcf_pkg::VTX_W'(1);
        end
      end
      HS_ISSUE: begin
        if (lvl_r < k_cur) begin
          re     = 1'b1;
          hs_nxt = HS_RUN;
        end else if (part_r == PART_X) begin
          // X sweep done, take one step of the H loop
          part_nxt = PART_H;
          lvl_nxt  = cgcf_pkg::VTX_W'(1);
        end else begin
          hs_nxt = HS_IDLE;
        end
      end
      HS_RUN: begin
        we = 1'b1;
        if (cur_c < lvl_r) begin
          wdata    = cur_c + 1'b1;
          do_swap  = 1'b1;
          pos_a    = base + (lvl_r[0] ? cur_c : '0);
          tgt_part = PART_X;
          tgt_lvl  = cgcf_pkg::VTX_W'(1);
        end else begin
          wdata    = '0;
          tgt_part = part_r;
          tgt_lvl  = lvl_r + 1'b1;
        end
        part_nxt = tgt_part;
        lvl_nxt  = tgt_lvl;
        tgt_k    = (tgt_part == PART_H) ? a_r : kx;
        if (tgt_lvl < tgt_k) begin
          re    = 1'b1;
          raddr = {tgt_part, tgt_lvl};
          // RAM is read-first: bypass the value written this cycle
          fwd_nxt      = ({tgt_part, tgt_lvl} == {part_r, lvl_r});
          fwd_data_nxt = wdata;
        end else begin
          hs_nxt = HS_ISSUE;
        end
      end
      default: begin
        hs_nxt = HS_IDLE;
      end
    endcase

    for (int k = 0; k < cgcf_pkg::N_VTX; k++) begin
      if (start_ok) begin
        perm_nxt[k] = cgcf_pkg::VTX_W'(k);
      end else if (do_swap && (cgcf_pkg::VTX_W'(k) == pos_a)) begin
        perm_nxt[k] = perm_r[pos_b];
      end else if (do_swap && (cgcf_pkg::VTX_W'(k) == pos_b)) begin
        perm_nxt[k] = perm_r[pos_a];
      end else begin
        perm_nxt[k] = perm_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_r    <= HS_IDLE;
      fwd_r   <= 1'b0;
      visit_r <= 1'b0;
    end else begin
      hs_r    <= hs_nxt;
      fwd_r   <= fwd_nxt;
      visit_r <= do_swap;
    end
  end

  always_ff @(posedge clk) begin
    part_r     <= part_nxt;
    lvl_r      <= lvl_nxt;
    clr_r      <= clr_nxt;
    fwd_data_r <= fwd_data_nxt;
    n_r        <= n_nxt;
    a_r        <= a_nxt;
    perm_r     <= perm_nxt;
  end

  assign perm       = perm_r;
  assign stat.idle  = (hs_r == HS_IDLE);
  assign stat.visit = visit_r;

endmodule

>>> design/cgcf_image.sv
module cgcf_image (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cgcf_pkg::job_t                job,
  input  cgcf_pkg::perm_t               perm,
  input  logic                          visit,
  output logic [cgcf_pkg::MASK_W-1:0]   best,
  output logic                          canon,
  output logic                          busy
);

  logic [cgcf_pkg::MASK_W-1:0] mask_r;
  logic [cgcf_pkg::MASK_W-1:0] best_r;
  logic [cgcf_pkg::MASK_W-1:0] img_r;
  logic [cgcf_pkg::MASK_W-1:0] img_c;
  logic                        img_v_r;

  // relabelled mask: edge (i,j) of the image is edge (perm[i],perm[j])
  always_comb begin
    img_c = '0;
    for (int j = 1; j < cgcf_pkg::N_VTX; j++) begin
      for (int i = 0; i < j; i++) begin
        img_c[cgcf_pkg::pair_idx(cgcf_pkg::VTX_W'(i), cgcf_pkg::VTX_W'(j))] =
          mask_r[cgcf_pkg::pair_idx(perm[i], perm[j])];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_v_r <= 1'b0;
    end else begin
      img_v_r <= visit;
    end
  end

  always_ff @(posedge clk) begin
    if (visit) begin
      img_r <= img_c;
    end
    if (job.start) begin
      mask_r <= job.mask;
      best_r <= job.mask;
    end else if (img_v_r && (img_r < best_r)) begin
      best_r <= img_r;
    end
  end

  assign best  = best_r;
  assign canon = (best_r == mask_r);
  assign busy  = visit | img_v_r;

endmodule

>>> design/cgcf_valid.sv
module cgcf_valid (
  input  logic           clk,
  input  logic           rst_n,
  input  cgcf_pkg::job_t job,
  output logic           ok,
  output logic           idle
);

  localparam logic [cgcf_pkg::VTX_W-1:0] SUB4 = 3'd4;
  localparam logic [cgcf_pkg::VTX_W-1:0] SUB5 = 3'd5;

  logic                           run_r;
  logic [cgcf_pkg::N_VTX-1:0]     cnt_r;
  logic                           ok_r;
  logic [cgcf_pkg::MASK_W-1:0]    mask_r;
  logic [cgcf_pkg::VTX_W-1:0]     n_r, a_r;

  logic [cgcf_pkg::N_VTX-1:0]     in_lo, h_lo;
  logic [cgcf_pkg::MASK_W-1:0]    pm, hit;
  logic [cgcf_pkg::VTX_W-1:0]     pop;
  logic                           in_range, all_h, all_x, clique, indep, fail;

  function automatic logic [cgcf_pkg::N_VTX-1:0] low_bits(
    input logic [cgcf_pkg::VTX_W-1:0] k);
    logic [cgcf_pkg::N_VTX:0] t;
    t = ({{cgcf_pkg::N_VTX{1'b0}}, 1'b1} << k) - 1'b1;
    return t[cgcf_pkg::N_VTX-1:0];
  endfunction

  // cnt_r walks every vertex subset; 4- and 5-subsets are checked
  always_comb begin
    in_lo = low_bits(n_r);
    h_lo  = low_bits(a_r);
    pop   = '0;
    for (int i = 0; i < cgcf_pkg::N_VTX; i++) begin
      pop = pop + {{(cgcf_pkg::VTX_W-1){1'b0}}, cnt_r[i]};
    end
    pm = '0;
    for (int j = 1; j < cgcf_pkg::N_VTX; j++) begin
      for (int i = 0; i < j; i++) begin
        pm[cgcf_pkg::pair_idx(cgcf_pkg::VTX_W'(i), cgcf_pkg::VTX_W'(j))] =
          cnt_r[i] & cnt_r[j];
      end
    end
    hit      = mask_r & pm;
    clique   = (hit == pm);
    indep    = (hit == '0);
    in_range = ((cnt_r & ~in_lo) == '0);
    all_h    = ((cnt_r & ~h_lo) == '0);
    all_x    = ((cnt_r & h_lo) == '0);
    fail     = in_range &&
               (((pop == SUB4) && ((all_h && clique) || (all_x && indep))) ||
                ((pop == SUB5) && (clique || indep)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else if (job.start) begin
      run_r <= 1'b1;
    end else if (run_r && (cnt_r == '1)) begin
      run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job.start) begin
      cnt_r  <= '0;
      ok_r   <= 1'b1;
      mask_r <= job.mask;
      n_r    <= job.n;
      a_r    <= job.a;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      ok_r  <= ok_r & ~fail;
    end
  end

  assign ok   = ok_r;
  assign idle = ~run_r;

endmodule

>>> design/colored_graph_canonical_filter.sv
// Canonical-form filter for two-part graphs on up to 7 vertices.
// Input channel (in_valid/in_ready/in_edge_mask): one transaction carries one
// graph as a packed upper-triangle edge mask. Output channel (out_valid/
// out_ready/out_*): one transaction per input with the minimum relabelled mask,
// the canonical flag, the validity flag and keep = canonical & valid.
// Config: cfg_we/cfg_index/cfg_wdata write order (index 0) or split (index 1);
// write only while the block is idle.
// The sequencer first clears all 16 counter-RAM entries, then runs Heap's
// algorithm with H as the outer and X as the inner loop, one counter
// read-modify-write per cycle within a sweep; the issue state between sweeps
// holds the flow. The validity sweep over all 128 vertex subsets runs
// alongside, and a graph finishes only when both are done.
// One graph is processed at a time. A new input is taken while the previous
// result still sits in the output register; a stalled receiver only holds
// back the finish of the next graph.
// Reset (rst_n low, synchronous): order = 7, split = 0, output empty.
`include "assert_macros.svh"

module colored_graph_canonical_filter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [cgcf_pkg::MASK_W-1:0]      in_edge_mask,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [cgcf_pkg::MASK_W-1:0]      out_minimal_image,
  output logic                             out_is_canonical,
  output logic                             out_is_valid,
  output logic                             out_keep,
  input  logic                             cfg_we,
  input  logic [cgcf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cgcf_pkg::VTX_W-1:0]       cfg_wdata
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [cgcf_pkg::VTX_W-1:0]  order_r, split_r;

  logic                        out_valid_r, out_valid_nxt;
  logic [cgcf_pkg::MASK_W-1:0] out_min_r;
  logic                        out_canon_r, out_ok_r;

  logic [cgcf_pkg::VTX_W-1:0]  n_eff, a_eff;
  logic [cgcf_pkg::PAIR_W-1:0] bits;
  logic [cgcf_pkg::MASK_W:0]   lim;
  logic                        load_out;

  cgcf_pkg::job_t              job;
  cgcf_pkg::perm_t             perm;
  cgcf_pkg::heap_stat_t        heap_stat;
  logic [cgcf_pkg::MASK_W-1:0] img_best;
  logic                        img_canon, img_busy;
  logic                        val_ok, val_idle;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= 3'd7;
      split_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cgcf_pkg::CFG_ORDER: order_r <= cfg_wdata;
        cgcf_pkg::CFG_SPLIT: split_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // order 0 acts as one vertex, split clamps to order; unused mask bits drop
  always_comb begin
    n_eff     = (order_r == '0) ? cgcf_pkg::VTX_W'(1) : order_r;
    a_eff     = (split_r > n_eff) ? n_eff : split_r;
    bits      = cgcf_pkg::pair_idx('0, n_eff);
    lim       = ({{cgcf_pkg::MASK_W{1'b0}}, 1'b1} << bits) - 1'b1;
    job.start = in_valid && in_ready;
    job.n     = n_eff;
    job.a     = a_eff;
    job.mask  = in_edge_mask & lim[cgcf_pkg::MASK_W-1:0];
  end

  cgcf_heap u_heap (
    .clk   (clk),
    .rst_n (rst_n),
    .job   (job),
    .perm  (perm),
    .stat  (heap_stat)
  );

  cgcf_image u_image (
    .clk   (clk),
    .rst_n (rst_n),
    .job   (job),
    .perm  (perm),
    .visit (heap_stat.visit),
    .best  (img_best),
    .canon (img_canon),
    .busy  (img_busy)
  );

  cgcf_valid u_valid (
    .clk   (clk),
    .rst_n (rst_n),
    .job   (job),
    .ok    (val_ok),
    .idle  (val_idle)
  );

  // top control: run until sequencer, image pipe and subset sweep are quiet
  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (job.start) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (heap_stat.idle && val_idle && !img_busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // wait here while the previous result is still unclaimed
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_min_r   <= img_best;
      out_canon_r <= img_canon;
      out_ok_r    <= val_ok;
    end
  end

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_minimal_image = out_min_r;
  assign out_is_canonical  = out_canon_r;
  assign out_is_valid      = out_ok_r;
  assign out_keep          = out_canon_r & out_ok_r;

  // sequencer and subset sweep are quiet whenever a new transaction can be taken
  `CGCF_ASSERT_IMP(a_idle_units, state_r == ST_IDLE, heap_stat.idle && val_idle)
  // permutation images only flow while a graph is being processed
  `CGCF_ASSERT_IMP(a_img_in_run, img_busy, state_r == ST_RUN)
  // every visit reaches the compare stage
  `CGCF_ASSERT_NEXT(a_visit_tracked, heap_stat.visit, img_busy)

endmodule
